[hw/rtl/image_rotate_flip_address_gen_assert.svh]
// Assertion macros used by the address generator's queue module.
`ifndef IMAGE_ROTATE_FLIP_ADDRESS_GEN_ASSERT_SVH
`define IMAGE_ROTATE_FLIP_ADDRESS_GEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IRF_ASSERT(label, clk, rst, prop) \
label: assert property (@(posedge clk) disable iff (rst) (prop)) \
else $error("irf assertion failed");
`define IRF_ASSERT_NEXT(label, clk, rst, pre, post) \
label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
else $error("irf assertion failed");
`else
`define IRF_ASSERT(label, clk, rst, prop)
`define IRF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[hw/rtl/irf_pkg.sv]
package irf_pkg;
   localparam int MAX_DIM_DEFAULT = 4096;
   localparam int CFG_DIM_W = 13;
   localparam int CFG_BPP_W = 3;
   localparam int CFG_MODE_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int PIXEL_W = 32;
   localparam int OFFSET_W = 26;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BPP = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 2'd3;

   localparam logic [CFG_MODE_W-1:0] MODE_ROT_LEFT = 2'd0;
   localparam logic [CFG_MODE_W-1:0] MODE_ROT_RIGHT = 2'd1;

   localparam logic [CFG_BPP_W-1:0] BPP_2 = 3'd2;
   localparam logic [CFG_BPP_W-1:0] BPP_3 = 3'd3;
   localparam logic [CFG_BPP_W-1:0] BPP_4 = 3'd4;

   function automatic logic [CFG_BPP_W-1:0] eff_bpp(input logic [CFG_BPP_W-1:0] raw);
      logic [CFG_BPP_W-1:0] r;
      if (raw < BPP_2) begin
         r = BPP_2;
      end else if (raw > BPP_4) begin
         r = BPP_4;
      end else begin
         r = raw;
      end
      return r;
   endfunction
endpackage

[hw/rtl/irf_req_if.sv]
interface irf_req_if;
   logic                         valid;
   logic                         ready;
   logic [irf_pkg::PIXEL_W-1:0]  pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

[hw/rtl/irf_rsp_if.sv]
interface irf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [irf_pkg::PIXEL_W-1:0]  pixel_out;
   logic [irf_pkg::OFFSET_W-1:0] dest_offset;
   logic                         frame_last;
   modport source (output valid, output pixel_out, output dest_offset, output frame_last,
                   input ready);
   modport sink (input valid, input pixel_out, input dest_offset, input frame_last,
                 output ready);
endinterface

[hw/rtl/irf_csr_if.sv]
interface irf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [irf_pkg::CSR_INDEX_W-1:0]  index;
   logic [irf_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/irf_front.sv]
module irf_front #(
   parameter int MAX_DIM = irf_pkg::MAX_DIM_DEFAULT,
   parameter int DIM_W = $clog2(MAX_DIM + 1),
   parameter int CNT_W = $clog2(MAX_DIM),
   parameter int ENTRY_W = irf_pkg::PIXEL_W + 3 * DIM_W + 1
) (
   input  logic                            clock,
   input  logic                            reset,
   irf_req_if.sink                         req,
   input  logic [DIM_W-1:0]                width_eff,
   input  logic [DIM_W-1:0]                height_eff,
   input  logic [irf_pkg::CFG_MODE_W-1:0]  mode,
   input  logic                            full,
   output logic                            push,
   output logic [ENTRY_W-1:0]              push_data
);
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] x, y, w_last, h_last;
   logic [DIM_W-1:0] mul_a, mul_b, addend;
   logic             at_col_end, at_row_end;

   assign req.ready = !full;
   assign push = req.valid && !full;

   always_comb begin
      w_last = width_eff - DIM_W'(1);
      h_last = height_eff - DIM_W'(1);
      x = (DIM_W'(col_ff) < width_eff) ? DIM_W'(col_ff) : w_last;
      y = (DIM_W'(row_ff) < height_eff) ? DIM_W'(row_ff) : h_last;
      at_col_end = (x == w_last);
      at_row_end = (y == h_last);
      priority if (mode == irf_pkg::MODE_ROT_LEFT) begin
         mul_a = x;
         mul_b = height_eff;
         addend = h_last - y;
      end else if (mode == irf_pkg::MODE_ROT_RIGHT) begin
         mul_a = w_last - x;
         mul_b = height_eff;
         addend = y;
      end else begin
         mul_a = h_last - y;
         mul_b = width_eff;
         addend = x;
      end
      push_data = {req.pixel, mul_a, mul_b, addend, at_col_end && at_row_end};
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (at_col_end) begin
            col_in = '0;
            row_in = at_row_end ? '0 : CNT_W'(y + DIM_W'(1));
         end else begin
            col_in = CNT_W'(x + DIM_W'(1));
            row_in = CNT_W'(y);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end
endmodule

[hw/rtl/irf_queue.sv]
module irf_queue #(
   parameter int DEPTH = irf_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   `include "image_rotate_flip_address_gen_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   `IRF_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `IRF_ASSERT(a_no_push_full, clock, reset, !(push && full))
   `IRF_ASSERT(a_no_pop_empty, clock, reset, !(pop && empty))
   `IRF_ASSERT_NEXT(a_count_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + CNT_W'(1))
endmodule

[hw/rtl/irf_back.sv]
module irf_back #(
   parameter int MAX_DIM = irf_pkg::MAX_DIM_DEFAULT,
   parameter int DIM_W = $clog2(MAX_DIM + 1),
   parameter int ENTRY_W = irf_pkg::PIXEL_W + 3 * DIM_W + 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           empty,
   input  logic [ENTRY_W-1:0]             pop_data,
   output logic                           pop,
   input  logic [irf_pkg::CFG_BPP_W-1:0]  bpp,
   irf_rsp_if.source                      rsp
);
   localparam int PROD_W = 2 * DIM_W;
   localparam int EXT_W = (PROD_W + 2 > irf_pkg::OFFSET_W) ? PROD_W + 2 : irf_pkg::OFFSET_W;

   logic [irf_pkg::PIXEL_W-1:0]  q_pixel;
   logic [DIM_W-1:0]             q_a, q_b, q_c;
   logic                         q_last;

   logic                         s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]            s1_prod_ff;
   logic [DIM_W-1:0]             s1_add_ff;
   logic [irf_pkg::PIXEL_W-1:0]  s1_pixel_ff;
   logic                         s1_last_ff;

   logic                         s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0]            s2_idx_ff;
   logic [irf_pkg::PIXEL_W-1:0]  s2_pixel_ff;
   logic                         s2_last_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [irf_pkg::OFFSET_W-1:0] out_offset_ff;
   logic [irf_pkg::PIXEL_W-1:0]  out_pixel_ff;
   logic                         out_last_ff;

   logic                         out_move, s2_move, s1_move;
   logic [EXT_W-1:0]             idx_ext, scaled;

   assign {q_pixel, q_a, q_b, q_c, q_last} = pop_data;

   assign out_move = !out_valid_ff || rsp.ready;
   assign s2_move = !s2_valid_ff || out_move;
   assign s1_move = !s1_valid_ff || s2_move;
   assign pop = s1_move && !empty;

   assign s1_valid_in = s1_move ? !empty : s1_valid_ff;
   assign s2_valid_in = s2_move ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_move ? s2_valid_ff : out_valid_ff;

   always_comb begin
      idx_ext = EXT_W'(s2_idx_ff);
      unique case (bpp)
         irf_pkg::BPP_2: scaled = idx_ext << 1;
         irf_pkg::BPP_3: scaled = idx_ext + (idx_ext << 1);
         default:        scaled = idx_ext << 2;
      endcase
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pixel_out = out_pixel_ff;
   assign rsp.dest_offset = out_offset_ff;
   assign rsp.frame_last = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (s1_move) begin
         s1_prod_ff <= PROD_W'(q_a) * PROD_W'(q_b);
         s1_add_ff <= q_c;
         s1_pixel_ff <= q_pixel;
         s1_last_ff <= q_last;
      end
      if (s2_move) begin
         s2_idx_ff <= s1_prod_ff + PROD_W'(s1_add_ff);
         s2_pixel_ff <= s1_pixel_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (out_move) begin
         out_offset_ff <= scaled[irf_pkg::OFFSET_W-1:0];
         out_pixel_ff <= s2_pixel_ff;
         out_last_ff <= s2_last_ff;
      end
   end
endmodule

[hw/rtl/image_rotate_flip_address_gen.sv]
// Destination address generator for rotating an image by 90 degrees either way or
// flipping it vertically. Source pixels arrive on the request channel in raster
// order, one word per pixel; each produces one response word carrying the pixel,
// its byte offset in the destination image and a flag on the final pixel of the
// frame. Column and row counters follow the raster and wrap after that pixel.
// Width, height, bytes per pixel and mode are written through the register
// channel, which is always ready. The user must write them only while no pixel
// is in flight; the block itself does not enforce this. A pixel is counted and
// classified in the front stage, waits in a queue of QUEUE_DEPTH entries (four
// by default), then passes a multiply stage, an add stage and the output
// register. The pipeline sustains one pixel per cycle unless the receiver stalls.
// When the receiver stalls, the output register holds its word, the back stages
// and then the queue fill, and request ready falls once the queue is full.
// Reset clears the counters, empties the queue and pipeline, and restores
// width 1, height 1, three bytes per pixel and left rotation.
module image_rotate_flip_address_gen #(
   parameter int MAX_DIM = irf_pkg::MAX_DIM_DEFAULT,
   parameter int QUEUE_DEPTH = irf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   irf_req_if.sink    req_chan,
   irf_rsp_if.source  rsp_chan,
   irf_csr_if.sink    csr_chan
);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int ENTRY_W = irf_pkg::PIXEL_W + 3 * DIM_W + 1;
   localparam int CMP_W = (DIM_W > irf_pkg::CFG_DIM_W) ? DIM_W : irf_pkg::CFG_DIM_W;

   logic [irf_pkg::CFG_DIM_W-1:0]  width_ff, width_in;
   logic [irf_pkg::CFG_DIM_W-1:0]  height_ff, height_in;
   logic [irf_pkg::CFG_BPP_W-1:0]  bpp_ff, bpp_in;
   logic [irf_pkg::CFG_MODE_W-1:0] mode_ff, mode_in;

   logic [DIM_W-1:0]   width_eff, height_eff;
   logic               push, pop, full, empty;
   logic [ENTRY_W-1:0] push_data, pop_data;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [irf_pkg::CFG_DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (CMP_W'(d) > CMP_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(d);
      end
      return r;
   endfunction

   assign csr_chan.ready = 1'b1;
   assign width_eff = clamp_dim(width_ff);
   assign height_eff = clamp_dim(height_ff);

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      bpp_in = bpp_ff;
      mode_in = mode_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            irf_pkg::REG_WIDTH:  width_in = csr_chan.data;
            irf_pkg::REG_HEIGHT: height_in = csr_chan.data;
            irf_pkg::REG_BPP:    bpp_in = csr_chan.data[irf_pkg::CFG_BPP_W-1:0];
            irf_pkg::REG_MODE:   mode_in = csr_chan.data[irf_pkg::CFG_MODE_W-1:0];
            default:             width_in = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= irf_pkg::CFG_DIM_W'(1);
         height_ff <= irf_pkg::CFG_DIM_W'(1);
         bpp_ff <= irf_pkg::BPP_3;
         mode_ff <= irf_pkg::MODE_ROT_LEFT;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         bpp_ff <= bpp_in;
         mode_ff <= mode_in;
      end
   end

   irf_front #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W),
      .CNT_W   (CNT_W),
      .ENTRY_W (ENTRY_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .mode       (mode_ff),
      .full       (full),
      .push       (push),
      .push_data  (push_data)
   );

   irf_queue #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   irf_back #(
      .MAX_DIM (MAX_DIM),
      .DIM_W   (DIM_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .pop_data (pop_data),
      .pop      (pop),
      .bpp      (irf_pkg::eff_bpp(bpp_ff)),
      .rsp      (rsp_chan)
   );
endmodule
